>>> sv/assert_macros.svh
// Assertion macros used by the quaternion-to-matrix RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`endif

>>> sv/q2m_pkg.sv
// Types and constants for the quaternion-to-matrix block.
// No dependencies.
package q2m_pkg;
  localparam int FracBitsDef = 14;
  localparam int WordBitsDef = 16;
  localparam int NumEntries = 9;

  typedef struct packed {
    logic signed [WordBitsDef-1:0] quat_x;
    logic signed [WordBitsDef-1:0] quat_y;
    logic signed [WordBitsDef-1:0] quat_z;
    logic signed [WordBitsDef-1:0] quat_w;
  } quat_t;

  typedef struct packed {
    logic signed [WordBitsDef-1:0] r00;
    logic signed [WordBitsDef-1:0] r01;
    logic signed [WordBitsDef-1:0] r02;
    logic signed [WordBitsDef-1:0] r10;
    logic signed [WordBitsDef-1:0] r11;
    logic signed [WordBitsDef-1:0] r12;
    logic signed [WordBitsDef-1:0] r20;
    logic signed [WordBitsDef-1:0] r21;
    logic signed [WordBitsDef-1:0] r22;
    logic                          degenerate;
  } mat_t;
endpackage

>>> sv/q2m_ratio_stage.sv
// One restoring step per entry of round(mag*2^F/n) for nine lanes.
// Depends on q2m_pkg.
module q2m_ratio_stage #(
  parameter int MagBits = 36
) (
  input  logic [8:0][MagBits-1:0] rem_in,
  input  logic [8:0][MagBits-1:0] acc_in,
  input  logic [MagBits-1:0]      n,
  output logic [8:0][MagBits-1:0] rem_out,
  output logic [8:0][MagBits-1:0] acc_out
);
  import q2m_pkg::*;
  logic [MagBits-1:0] diff;
  always_comb begin
    diff = '0;
    for (int i = 0; i < NumEntries; i++) begin
      diff = n - rem_in[i];
      if (rem_in[i] >= diff) begin
        acc_out[i] = {acc_in[i][MagBits-2:0], 1'b1};
        rem_out[i] = rem_in[i] - diff;
      end else begin
        acc_out[i] = {acc_in[i][MagBits-2:0], 1'b0};
        rem_out[i] = {rem_in[i][MagBits-2:0], 1'b0};
      end
    end
  end
endmodule

>>> sv/quaternion_to_rotation_matrix.sv
// Quaternion (x,y,z,w) to 3x3 rotation matrix, deep pipeline.
// Channels: in (in_valid/in_stall/in_data), out (out_valid/out_stall/out_data),
// payloads are q2m_pkg::quat_t and q2m_pkg::mat_t.
// Stage 1 squares and products, stage 2 norm and signed numerators,
// stage 3 takes the integer quotient bit, stages 4..FRAC_BITS+4 one restoring
// fraction bit each, then rounding and saturation feed the output register.
// Throughput: one item per cycle unless stalled; every stage advances whenever the output
// register is empty or being taken.
// Stall: while out_stall is high with a result waiting, the whole pipe holds,
// in_stall rises, nothing is lost or repeated.
// Reset: all valid bits clear; payload registers are not reset.
// A zero quaternion gives the identity matrix with degenerate set.
`include "assert_macros.svh"
module quaternion_to_rotation_matrix #(
  parameter int FRAC_BITS = q2m_pkg::FracBitsDef
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  q2m_pkg::quat_t  in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output q2m_pkg::mat_t   out_data
);
  import q2m_pkg::*;
  localparam int W = WordBitsDef;
  localparam int MagBits = 2 * W + 4;
  localparam int Steps = FRAC_BITS + 1;
  localparam logic [MagBits-1:0] WMaxP = MagBits'((64'd1 << (W - 1)) - 1);
  localparam logic [MagBits-1:0] OneQ = MagBits'(64'd1 << FRAC_BITS);

  logic adv;
  assign adv = !out_valid || !out_stall;
  assign in_stall = !adv;

  // stage 1: products
  logic s1_valid;
  logic signed [2*W-1:0] xx, yy, zz, ww, xy, wz, xz, wy, yz, wx;
  logic signed [W-1:0] qx, qy, qz, qw;
  always_comb begin
    qx = in_data.quat_x; qy = in_data.quat_y;
    qz = in_data.quat_z; qw = in_data.quat_w;
    // all four at the minimum give the same matrix as all ones
    if (qx == {1'b1, {(W-1){1'b0}}} && qy == {1'b1, {(W-1){1'b0}}} &&
        qz == {1'b1, {(W-1){1'b0}}} && qw == {1'b1, {(W-1){1'b0}}}) begin
      qx = W'(1); qy = W'(1); qz = W'(1); qw = W'(1);
    end
  end
  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else if (adv) s1_valid <= in_valid;
    if (adv) begin
      xx <= qx * qx; yy <= qy * qy; zz <= qz * qz; ww <= qw * qw;
      xy <= qx * qy; wz <= qw * qz; xz <= qx * qz;
      wy <= qw * qy; yz <= qy * qz; wx <= qw * qx;
    end
  end

  // stage 2: norm, magnitudes and signs
  logic s2_valid;
  logic [MagBits-1:0] n2;
  logic [8:0][MagBits-1:0] mag2;
  logic [8:0] neg2;
  logic [8:0][MagBits-1:0] mag_c;
  logic [8:0] neg_c;
  logic signed [MagBits-1:0] pos_t, neg_t;

  function automatic logic signed [MagBits-1:0] sx(input logic signed [2*W-1:0] v);
    sx = MagBits'(v);
  endfunction

  always_comb begin
    pos_t = '0; neg_t = '0;
    for (int i = 0; i < NumEntries; i++) begin
      case (i)
        0: begin pos_t = sx(xx) + sx(ww); neg_t = sx(yy) + sx(zz); end
        1: begin pos_t = sx(xy) <<< 1; neg_t = sx(wz) <<< 1; end
        2: begin pos_t = sx(xz) <<< 1; neg_t = -(sx(wy) <<< 1); end
        3: begin pos_t = sx(xy) <<< 1; neg_t = -(sx(wz) <<< 1); end
        4: begin pos_t = sx(yy) + sx(ww); neg_t = sx(xx) + sx(zz); end
        5: begin pos_t = sx(yz) <<< 1; neg_t = sx(wx) <<< 1; end
        6: begin pos_t = sx(xz) <<< 1; neg_t = sx(wy) <<< 1; end
        7: begin pos_t = sx(yz) <<< 1; neg_t = -(sx(wx) <<< 1); end
        default: begin pos_t = sx(zz) + sx(ww); neg_t = sx(xx) + sx(yy); end
      endcase
      neg_c[i] = pos_t < neg_t;
      mag_c[i] = neg_c[i] ? MagBits'(neg_t - pos_t) : MagBits'(pos_t - neg_t);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) s2_valid <= 1'b0;
    else if (adv) s2_valid <= s1_valid;
    if (adv) begin
      n2 <= MagBits'(sx(xx) + sx(yy) + sx(zz) + sx(ww));
      mag2 <= mag_c;
      neg2 <= neg_c;
    end
  end

  // divider pipeline: initial integer bit then Steps fraction steps
  logic [Steps:0] dv_valid;
  logic [Steps:0][MagBits-1:0] dv_n;
  logic [Steps:0][8:0] dv_neg;
  logic [Steps:0][8:0][MagBits-1:0] dv_rem, dv_acc;
  logic [Steps-1:0][8:0][MagBits-1:0] st_rem, st_acc;

  always_ff @(posedge clk) begin
    if (rst) dv_valid[0] <= 1'b0;
    else if (adv) dv_valid[0] <= s2_valid;
    if (adv) begin
      dv_n[0] <= n2;
      dv_neg[0] <= neg2;
      for (int i = 0; i < NumEntries; i++) begin
        if (mag2[i] >= n2) begin
          dv_acc[0][i] <= MagBits'(1);
          dv_rem[0][i] <= mag2[i] - n2;
        end else begin
          dv_acc[0][i] <= '0;
          dv_rem[0][i] <= mag2[i];
        end
      end
    end
  end

  for (genvar s = 0; s < Steps; s++) begin : g_div
    q2m_ratio_stage #(.MagBits(MagBits)) u_step (
      .rem_in(dv_rem[s]), .acc_in(dv_acc[s]), .n(dv_n[s]),
      .rem_out(st_rem[s]), .acc_out(st_acc[s])
    );
    always_ff @(posedge clk) begin
      if (rst) dv_valid[s+1] <= 1'b0;
      else if (adv) dv_valid[s+1] <= dv_valid[s];
      if (adv) begin
        dv_n[s+1] <= dv_n[s];
        dv_neg[s+1] <= dv_neg[s];
        dv_rem[s+1] <= st_rem[s];
        dv_acc[s+1] <= st_acc[s];
      end
    end
  end

  // round, saturate, output register
  logic [8:0][W-1:0] ent;
  logic [MagBits-1:0] q;
  logic degen;
  always_comb begin
    q = '0;
    degen = dv_n[Steps] == '0;
    for (int i = 0; i < NumEntries; i++) begin
      q = (dv_acc[Steps][i] + MagBits'(1)) >> 1;
      if (degen) q = (i == 0 || i == 4 || i == 8) ? OneQ : '0;
      if (!dv_neg[Steps][i] || degen)
        ent[i] = (q > WMaxP) ? WMaxP[W-1:0] : q[W-1:0];
      else
        ent[i] = (q > WMaxP + 1) ? W'(WMaxP + 1) : W'(-q);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= dv_valid[Steps];
    if (adv) begin
      out_data.r00 <= ent[0]; out_data.r01 <= ent[1]; out_data.r02 <= ent[2];
      out_data.r10 <= ent[3]; out_data.r11 <= ent[4]; out_data.r12 <= ent[5];
      out_data.r20 <= ent[6]; out_data.r21 <= ent[7]; out_data.r22 <= ent[8];
      out_data.degenerate <= degen;
    end
  end

  `ASSERT_NEXT(a_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_data))
  `ASSERT_IMPLIES(a_stall, clk, rst, in_stall, out_valid && out_stall)
  `ASSERT_IMPLIES(a_degen_id, clk, rst, out_valid && out_data.degenerate,
    out_data.r01 == '0 && out_data.r10 == '0 && out_data.r22 != '0)
endmodule

>>> tb/quaternion_to_rotation_matrix_tb.sv
// Testbench for quaternion_to_rotation_matrix: directed table, then random quaternions,
// checked against table rows or an integer predictor. Depends on q2m_pkg and the DUT.
`timescale 1ns / 100ps
module quaternion_to_rotation_matrix_tb;
  import q2m_pkg::*;

  localparam int FracBits = FracBitsDef;
  localparam int RandItems = 900;
  localparam int WatchdogLimit = 20000;
  localparam int DrainCycles = 40;
  localparam logic signed [15:0] QOne = 16'sd16384;
  localparam logic signed [15:0] QMin = -16'sd32768;
  localparam logic signed [15:0] QMax = 16'sd32767;

  typedef struct {
    quat_t q;
    bit    has_exp;
    mat_t  m;
  } stim_row_t;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  in_valid = 1'b0;
  logic  in_stall;
  quat_t in_data = '0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  mat_t  out_data;

  mat_t      pending_mats[$];
  stim_row_t rows[$];
  int        mismatches = 0;
  int        idle_cycles = 0;
  bit        stim_done = 1'b0;

  quaternion_to_rotation_matrix dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // round(mag * 2^FracBits / n), ties away from zero, then saturate with sign
  function automatic logic signed [15:0] scaled_entry(longint num, longint n);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = ((mag << (FracBits + 1)) / n + 1) >>> 1;
    if (num < 0) return (q > 32768) ? QMin : 16'(-q);
    return (q > 32767) ? QMax : 16'(q);
  endfunction

  function automatic mat_t rotation_of(quat_t q);
    longint x, y, z, w, xx, yy, zz, ww, n;
    mat_t m;
    x = q.quat_x; y = q.quat_y; z = q.quat_z; w = q.quat_w;
    // all four at minimum: same rotation as (1,1,1,1)
    if (x == -32768 && y == -32768 && z == -32768 && w == -32768) begin
      x = 1; y = 1; z = 1; w = 1;
    end
    xx = x * x; yy = y * y; zz = z * z; ww = w * w;
    n = xx + yy + zz + ww;
    m = '0;
    if (n == 0) begin
      m.r00 = QOne; m.r11 = QOne; m.r22 = QOne;
      m.degenerate = 1'b1;
      return m;
    end
    m.r00 = scaled_entry(xx + ww - yy - zz, n);
    m.r01 = scaled_entry(2 * (x * y - w * z), n);
    m.r02 = scaled_entry(2 * (x * z + w * y), n);
    m.r10 = scaled_entry(2 * (x * y + w * z), n);
    m.r11 = scaled_entry(yy + ww - xx - zz, n);
    m.r12 = scaled_entry(2 * (y * z - w * x), n);
    m.r20 = scaled_entry(2 * (x * z - w * y), n);
    m.r21 = scaled_entry(2 * (y * z + w * x), n);
    m.r22 = scaled_entry(zz + ww - xx - yy, n);
    return m;
  endfunction

  function automatic quat_t mk_quat(logic signed [15:0] x, logic signed [15:0] y,
                                    logic signed [15:0] z, logic signed [15:0] w);
    quat_t q;
    q.quat_x = x; q.quat_y = y; q.quat_z = z; q.quat_w = w;
    return q;
  endfunction

  function automatic mat_t mk_mat(logic signed [15:0] d0, logic signed [15:0] d1,
                                  logic signed [15:0] d2, logic degen);
    mat_t m;
    m = '0;
    m.r00 = d0; m.r11 = d1; m.r22 = d2; m.degenerate = degen;
    return m;
  endfunction

  function automatic logic signed [15:0] rand_component();
    case ($urandom_range(0, 5))
      0: return QMin;
      1: return QMax;
      2: return 16'($urandom_range(0, 64)) - 16'sd32;
      3: return 16'($urandom_range(0, 32768)) - 16'sd16384;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic add_row(quat_t q, bit has_exp, mat_t m);
    stim_row_t r;
    r.q = q; r.has_exp = has_exp; r.m = m;
    rows.push_back(r);
  endtask

  // in_valid stays high after an accept when the next item follows at once
  task automatic send_quat(quat_t q, mat_t expected);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data <= q;
    in_valid <= 1'b1;
    pending_mats.push_back(expected);
    do @(posedge clk); while (in_stall);
  endtask

  task automatic build_directed();
    mat_t none;
    none = '0;
    add_row(mk_quat(0, 0, 0, 0), 1, mk_mat(QOne, QOne, QOne, 1'b1));
    add_row(mk_quat(0, 0, 0, QOne), 1, mk_mat(QOne, QOne, QOne, 1'b0));
    add_row(mk_quat(0, 0, 0, 1), 1, mk_mat(QOne, QOne, QOne, 1'b0));
    add_row(mk_quat(0, 0, 0, QMin), 1, mk_mat(QOne, QOne, QOne, 1'b0));
    add_row(mk_quat(QOne, 0, 0, 0), 1, mk_mat(QOne, -QOne, -QOne, 1'b0));
    add_row(mk_quat(0, QMax, 0, 0), 1, mk_mat(-QOne, QOne, -QOne, 1'b0));
    add_row(mk_quat(0, 0, QMin, 0), 1, mk_mat(-QOne, -QOne, QOne, 1'b0));
    add_row(mk_quat(QMin, QMin, QMin, QMin), 0, none);
    add_row(mk_quat(1, 1, 1, 1), 0, none);
    add_row(mk_quat(QMax, QMax, QMax, QMax), 0, none);
    add_row(mk_quat(QMin, QMax, QMin, QMax), 0, none);
    add_row(mk_quat(QMax, QMin, QMax, QMin), 0, none);
    add_row(mk_quat(QMin, QMin, QMin, QMax), 0, none);
    add_row(mk_quat(-1, -1, -1, -1), 0, none);
    add_row(mk_quat(1, 0, 0, 1), 0, none);
    add_row(mk_quat(0, 1, 0, 1), 0, none);
    add_row(mk_quat(0, 0, 1, -1), 0, none);
    add_row(mk_quat(11585, 0, 0, 11585), 0, none);
    add_row(mk_quat(1, 2, 3, 4), 0, none);
    add_row(mk_quat(16'sh5555, -16'sh5556, 16'sh2aaa, 16'sh7fff), 0, none);
  endtask

  initial begin
    build_directed();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (rows[i])
      send_quat(rows[i].q, rows[i].has_exp ? rows[i].m : rotation_of(rows[i].q));
    for (int i = 0; i < RandItems; i++) begin
      quat_t q;
      q = mk_quat(rand_component(), rand_component(), rand_component(), rand_component());
      if ($urandom_range(0, 29) == 0) q = '0;
      send_quat(q, rotation_of(q));
      // let the pipe empty once, midway
      if (i == RandItems / 2) begin
        in_valid <= 1'b0;
        while (pending_mats.size() != 0) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // receiver stall: bursts of random length, with quiet stretches
  initial begin
    int len;
    @(negedge rst);
    forever begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 3);
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      out_stall <= (len != 0);
      repeat (len == 0 ? 1 : len) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      mat_t exp_m;
      if (pending_mats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected matrix %h", out_data);
      end else begin
        exp_m = pending_mats.pop_front();
        if (out_data !== exp_m) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: matrix mismatch expected %h got %h", exp_m, out_data);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    int drain;
    drain = 0;
    @(negedge rst);
    while (!(stim_done && pending_mats.size() == 0) && idle_cycles < WatchdogLimit)
      @(posedge clk);
    while (drain < DrainCycles && idle_cycles < WatchdogLimit) begin
      @(posedge clk);
      drain++;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("Simulation FAILED");
    end else if (mismatches == 0 && pending_mats.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
